@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, skipped while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that holds on every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/npps_pkg.sv @@
// Types and constants of the nonpreemptive priority scheduler.
`timescale 1ns / 1ps
package npps_pkg;

   localparam int TIME_W       = 20;  // schedule times, 1000000 ticks and beyond fit
   localparam int IN_TIME_W    = 15;  // clamped arrival and burst times
   localparam int RESULT_LIMIT = 32;  // segments per schedule at most
   localparam int RES_CNT_W    = 6;

   localparam logic SEG_IDLE = 1'b0;
   localparam logic SEG_RUN  = 1'b1;

   typedef struct packed {
      logic [15:0]        process_id;
      logic signed [15:0] arrival_time;
      logic signed [15:0] burst_time;
      logic [15:0]        priority_level;
      logic               last_process;
   } req_type;

   typedef struct packed {
      logic              segment_kind;
      logic [3:0]        slot;
      logic [15:0]       run_id;
      logic [TIME_W-1:0] end_time;
      logic [TIME_W-1:0] turnaround;
      logic [TIME_W-1:0] waiting;
      logic              last_segment;
   } rsp_type;

   typedef struct packed {
      logic accept;       // load one process transfer
      logic sched_start;  // clear time, counts and finished flags
      logic scan_init;    // restart the candidate scan
      logic scan_step;    // examine one store entry
      logic emit;         // commit the decision and load the result register
      logic sched_end;    // empty the store
   } ctl_cmd_type;

   typedef struct packed {
      logic scan_last;    // entry under scan is the last loaded one
      logic out_free;     // result register can take a segment this cycle
      logic sched_done;   // segment being emitted ends the schedule
   } ctl_status_type;

endpackage

@@ rtl/npps_ctrl.sv @@
// Sequencer for loading, scanning and emitting schedule segments.
`timescale 1ns / 1ps
module npps_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_last,
   output logic                    req_stall,
   output npps_pkg::ctl_cmd_type   cmd,
   input  npps_pkg::ctl_status_type status
);
   import npps_pkg::*;

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_LOAD: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid && req_last) begin
               cmd.sched_start = 1'b1;
               cmd.scan_init   = 1'b1;
               state_in        = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.sched_done) begin
                  cmd.sched_end = 1'b1;
                  state_in      = ST_LOAD;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in      = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/npps_datapath.sv @@
// Process store, candidate scan, time arithmetic and result register.
`timescale 1ns / 1ps
module npps_datapath #(
   parameter int MAX_PROCESSES = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  npps_pkg::ctl_cmd_type    cmd,
   output npps_pkg::ctl_status_type status,
   input  npps_pkg::req_type        req,
   output npps_pkg::rsp_type        rsp,
   output logic                     rsp_valid,
   input  logic                     rsp_stall
);
   import npps_pkg::*;

   localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

   // process store, written in load order
   logic [15:0]          id_store_ff       [MAX_PROCESSES];
   logic [IN_TIME_W-1:0] arrival_store_ff  [MAX_PROCESSES];
   logic [IN_TIME_W-1:0] burst_store_ff    [MAX_PROCESSES];
   logic [15:0]          priority_store_ff [MAX_PROCESSES];

   logic [MAX_PROCESSES-1:0] fin_ff, fin_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         done_cnt_ff, done_cnt_in;
   logic [RES_CNT_W-1:0]     res_cnt_ff, res_cnt_in;
   logic [TIME_W-1:0]        time_ff, time_in;
   logic [IDX_W-1:0]         scan_idx_ff, scan_idx_in;
   logic                     found_ff, found_in;
   logic                     any_ff, any_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // best candidate so far and earliest pending arrival
   logic [IDX_W-1:0]     best_idx_ff;
   logic [15:0]          best_id_ff;
   logic [15:0]          best_prio_ff;
   logic [IN_TIME_W-1:0] best_arr_ff;
   logic [IN_TIME_W-1:0] best_burst_ff;
   logic [IN_TIME_W-1:0] min_arr_ff;
   rsp_type              rsp_ff, rsp_in;

   logic [IN_TIME_W-1:0] arr_clamp, burst_clamp;
   logic                 store_room;
   logic [15:0]          cur_id, cur_prio;
   logic [IN_TIME_W-1:0] cur_arr, cur_burst;
   logic                 cur_fin, ready, better, earlier, take;
   logic [TIME_W-1:0]    end_time, tat_time, wait_time;
   logic [CNT_W-1:0]     done_inc;
   logic [RES_CNT_W-1:0] res_inc;
   logic                 is_final;
   logic [31:0]          slot_wide;

   assign arr_clamp   = req.arrival_time[15] ? '0 : req.arrival_time[IN_TIME_W-1:0];
   assign burst_clamp = req.burst_time[15] ? '0 : req.burst_time[IN_TIME_W-1:0];
   assign store_room  = count_ff < CNT_W'(MAX_PROCESSES);

   assign cur_id    = id_store_ff[scan_idx_ff];
   assign cur_prio  = priority_store_ff[scan_idx_ff];
   assign cur_arr   = arrival_store_ff[scan_idx_ff];
   assign cur_burst = burst_store_ff[scan_idx_ff];
   assign cur_fin   = fin_ff[scan_idx_ff];

   // lower priority number wins, then smaller id, then lower slot (strict compare)
   assign ready   = !cur_fin && (TIME_W'(cur_arr) <= time_ff);
   assign better  = !found_ff || (cur_prio < best_prio_ff) ||
                    ((cur_prio == best_prio_ff) && (cur_id < best_id_ff));
   assign take    = ready && better;
   assign earlier = !cur_fin && (!any_ff || (cur_arr < min_arr_ff));

   assign end_time  = time_ff + TIME_W'(best_burst_ff);
   assign wait_time = time_ff - TIME_W'(best_arr_ff);
   assign tat_time  = end_time - TIME_W'(best_arr_ff);
   assign done_inc  = done_cnt_ff + CNT_W'(1);
   assign res_inc   = res_cnt_ff + RES_CNT_W'(1);
   assign is_final  = found_ff && (done_inc == count_ff);
   assign slot_wide = 32'(best_idx_ff);

   assign status.scan_last  = (CNT_W'(scan_idx_ff) == (count_ff - CNT_W'(1)));
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign status.sched_done = is_final || (res_inc == RES_CNT_W'(RESULT_LIMIT));

   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      count_in     = count_ff;
      done_cnt_in  = done_cnt_ff;
      res_cnt_in   = res_cnt_ff;
      time_in      = time_ff;
      fin_in       = fin_ff;
      scan_idx_in  = scan_idx_ff;
      found_in     = found_ff;
      any_in       = any_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      if (cmd.accept && store_room) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.sched_end) begin
         count_in = '0;
      end
      if (cmd.sched_start) begin
         time_in     = '0;
         done_cnt_in = '0;
         res_cnt_in  = '0;
         fin_in      = '0;
      end
      if (cmd.scan_init) begin
         scan_idx_in = '0;
         found_in    = 1'b0;
         any_in      = 1'b0;
      end
      if (cmd.scan_step) begin
         scan_idx_in = scan_idx_ff + IDX_W'(1);
         if (take) begin
            found_in = 1'b1;
         end
         if (earlier) begin
            any_in = 1'b1;
         end
      end
      if (cmd.emit) begin
         res_cnt_in   = res_inc;
         rsp_valid_in = 1'b1;
         if (found_ff) begin
            time_in              = end_time;
            fin_in[best_idx_ff]  = 1'b1;
            done_cnt_in          = done_inc;
            rsp_in.segment_kind  = SEG_RUN;
            rsp_in.slot          = slot_wide[3:0];
            rsp_in.run_id        = best_id_ff;
            rsp_in.end_time      = end_time;
            rsp_in.turnaround    = tat_time;
            rsp_in.waiting       = wait_time;
            rsp_in.last_segment  = is_final;
         end else begin
            // nothing has arrived: jump to the earliest pending arrival
            time_in              = TIME_W'(min_arr_ff);
            rsp_in.segment_kind  = SEG_IDLE;
            rsp_in.slot          = '0;
            rsp_in.run_id        = '0;
            rsp_in.end_time      = TIME_W'(min_arr_ff);
            rsp_in.turnaround    = '0;
            rsp_in.waiting       = '0;
            rsp_in.last_segment  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         done_cnt_ff  <= '0;
         res_cnt_ff   <= '0;
         time_ff      <= '0;
         fin_ff       <= '0;
         scan_idx_ff  <= '0;
         found_ff     <= 1'b0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         done_cnt_ff  <= done_cnt_in;
         res_cnt_ff   <= res_cnt_in;
         time_ff      <= time_in;
         fin_ff       <= fin_in;
         scan_idx_ff  <= scan_idx_in;
         found_ff     <= found_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && store_room) begin
         id_store_ff[count_ff[IDX_W-1:0]]       <= req.process_id;
         arrival_store_ff[count_ff[IDX_W-1:0]]  <= arr_clamp;
         burst_store_ff[count_ff[IDX_W-1:0]]    <= burst_clamp;
         priority_store_ff[count_ff[IDX_W-1:0]] <= req.priority_level;
      end
      if (cmd.scan_step && take) begin
         best_idx_ff   <= scan_idx_ff;
         best_id_ff    <= cur_id;
         best_prio_ff  <= cur_prio;
         best_arr_ff   <= cur_arr;
         best_burst_ff <= cur_burst;
      end
      if (cmd.scan_step && earlier) begin
         min_arr_ff <= cur_arr;
      end
      rsp_ff <= rsp_in;
   end

endmodule

@@ rtl/nonpreemptive_priority_scheduler_unit.sv @@
// Top level of the nonpreemptive priority scheduler.
// Loading: one process transfer per cycle while the block is ready.
// After the transfer flagged last, each segment is a scan over all n loaded entries
// and an emit; a schedule has up to 2n segments, capped at 32.
// The scan takes the store one entry at a time; a stalled result holds emit.
// Reset is synchronous, active high: control clears, store contents stay undefined.
`timescale 1ns / 1ps
module nonpreemptive_priority_scheduler_unit #(
   parameter int MAX_PROCESSES = 16
) (
   input  logic              clock,
   input  logic              reset,
   // process load channel
   input  logic              req_valid,
   output logic              req_stall,
   input  npps_pkg::req_type req,
   // schedule segment channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output npps_pkg::rsp_type rsp
);
   import npps_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   // Controller: LOAD takes process transfers; the transfer flagged last
   // clears time and finished flags and starts the first scan.
   npps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req.last_process),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath: each scan visits one store entry per cycle, keeping the
   // best ready candidate (priority, then id, then slot) and the earliest
   // pending arrival. The emit cycle commits either a run or an idle gap into
   // the result register, which parts the two channels.
   npps_datapath #(
      .MAX_PROCESSES (MAX_PROCESSES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req       (req),
      .rsp       (rsp),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall)
   );

endmodule

@@ rtl/npps_checker.sv @@
// Port-level checks for the scheduler, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module npps_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input npps_pkg::rsp_type rsp
);
   import npps_pkg::*;

   logic held, idle_seen, idle_clean, run_seen, run_ordered, ready_idle;

   assign held        = rsp_valid && rsp_stall;
   assign idle_seen   = rsp_valid && (rsp.segment_kind == SEG_IDLE);
   assign idle_clean  = (rsp.slot == 4'd0) && (rsp.run_id == 16'd0) &&
                        (rsp.turnaround == '0) && (rsp.waiting == '0) &&
                        !rsp.last_segment;
   assign run_seen    = rsp_valid && (rsp.segment_kind == SEG_RUN);
   assign run_ordered = (rsp.waiting <= rsp.turnaround) && (rsp.turnaround <= rsp.end_time);
   assign ready_idle  = !req_stall && !rsp_valid;

   `ASSERT_CLK(a_hold, clock, reset, held |=> rsp_valid && $stable(rsp), "stalled segment moved")
   `ASSERT_CLK(a_idle_zero, clock, reset, idle_seen |-> idle_clean, "idle segment has run fields")
   `ASSERT_CLK(a_run_order, clock, reset, run_seen |-> run_ordered, "run times out of order")
   `ASSERT_CLK(a_after_reset, clock, reset, $past(reset) |-> ready_idle, "not ready after reset")

endmodule

bind nonpreemptive_priority_scheduler_unit npps_checker u_npps_checker (.*);

@@ sim/tb.sv @@
// Self-checking testbench for the nonpreemptive priority scheduler unit.
`timescale 1ns / 1ps
module tb;
   import npps_pkg::*;

   localparam int MAX_PROC     = 16;
   localparam int RANDOM_ITEMS = 270;     // random part, on top of the directed sets
   localparam int SETTLE_CYCLES = 600;    // one full 16-process schedule scan and then some
   localparam int MAX_REPORTS  = 40;

   // one queued process transfer plus the handshake pacing that goes with it
   typedef struct {
      req_type     item;
      int unsigned idle_pct;
      int unsigned stall_pct;
      bit          wait_drain;   // hold off until every pending segment is back
   } load_entry_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   load_entry_type load_q[$];
   rsp_type        segment_q[$];      // segments the schedule is still owed
   int unsigned    stall_pct = 0;

   // scheduler image: process store in load order
   logic [15:0] proc_id     [MAX_PROC];
   logic [14:0] proc_arrival[MAX_PROC];
   logic [14:0] proc_burst  [MAX_PROC];
   logic [15:0] proc_prio   [MAX_PROC];
   bit          proc_done   [MAX_PROC];
   int unsigned proc_count = 0;

   int unsigned error_count = 0;
   int unsigned items_loaded = 0;
   int unsigned dropped_count = 0;
   int unsigned schedule_count = 0;
   int unsigned run_segments = 0;
   int unsigned idle_segments = 0;

   nonpreemptive_priority_scheduler_unit #(
      .MAX_PROCESSES(MAX_PROC)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req      (req),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp      (rsp)
   );

   always #5 clock = ~clock;

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // negative ticks clamp to zero; what is left fits in 15 bits
   function automatic logic [14:0] clamp_tick(logic signed [15:0] raw);
      return raw[15] ? 15'd0 : raw[14:0];
   endfunction

   // Works out every segment of the schedule for the processes now in the store,
   // queues them, then empties the store for the next set.
   function automatic void plan_schedule();
      int unsigned now, completed, n_seg, best, earliest;
      bit          found, any_left;
      rsp_type     seg;
      now = 0;
      completed = 0;
      n_seg = 0;
      for (int i = 0; i < MAX_PROC; i++) proc_done[i] = 1'b0;
      while (completed < proc_count && n_seg < RESULT_LIMIT) begin
         found = 1'b0;
         best = 0;
         // lowest priority number among arrived ones, then smaller id, then lower slot
         for (int i = 0; i < proc_count; i++) begin
            if (!proc_done[i] && 32'(proc_arrival[i]) <= now &&
                (!found || proc_prio[i] < proc_prio[best] ||
                 (proc_prio[i] == proc_prio[best] && proc_id[i] < proc_id[best]))) begin
               best = i;
               found = 1'b1;
            end
         end
         seg = '0;
         if (!found) begin
            // nothing ready: idle up to the earliest pending arrival
            any_left = 1'b0;
            earliest = 0;
            for (int i = 0; i < proc_count; i++) begin
               if (!proc_done[i] && (!any_left || 32'(proc_arrival[i]) < earliest)) begin
                  earliest = 32'(proc_arrival[i]);
                  any_left = 1'b1;
               end
            end
            now = earliest;
            seg.segment_kind = SEG_IDLE;
            seg.end_time = now[TIME_W-1:0];
         end else begin
            now += 32'(proc_burst[best]);
            completed++;
            proc_done[best] = 1'b1;
            seg.segment_kind = SEG_RUN;
            seg.slot = best[3:0];
            seg.run_id = proc_id[best];
            seg.end_time = now[TIME_W-1:0];
            seg.turnaround = TIME_W'(now - 32'(proc_arrival[best]));
            seg.waiting = TIME_W'(now - 32'(proc_arrival[best]) - 32'(proc_burst[best]));
            seg.last_segment = (completed == proc_count);
         end
         segment_q.push_back(seg);
         n_seg++;
      end
      proc_count = 0;
      schedule_count++;
   endfunction

   function automatic void store_process(req_type p);
      if (proc_count < MAX_PROC) begin
         proc_id[proc_count] = p.process_id;
         proc_arrival[proc_count] = clamp_tick(p.arrival_time);
         proc_burst[proc_count] = clamp_tick(p.burst_time);
         proc_prio[proc_count] = p.priority_level;
         proc_count++;
      end else begin
         dropped_count++;   // store full: the process is lost, its last flag is not
      end
      items_loaded++;
      if (p.last_process) plan_schedule();
   endfunction

   function automatic void compare_field(string name, longint unsigned want,
                                         longint unsigned got);
      if (want != got) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endfunction

   // Driver: a new transfer goes out only once the previous one is taken,
   // so a stalled payload never moves and valid never looks at stall.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) store_process(req);
         if (!req_valid || !req_stall) begin
            if (load_q.size() != 0 && !(load_q[0].wait_drain && segment_q.size() != 0) &&
                $urandom_range(99) >= load_q[0].idle_pct) begin
               req <= load_q[0].item;
               req_valid <= 1'b1;
               stall_pct <= load_q[0].stall_pct;
               load_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each segment transfer against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (segment_q.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: unexpected segment, expected none actual %0h", $time, rsp);
            end else begin
               compare_field("segment_kind", segment_q[0].segment_kind, rsp.segment_kind);
               compare_field("slot", segment_q[0].slot, rsp.slot);
               compare_field("run_id", segment_q[0].run_id, rsp.run_id);
               compare_field("end_time", segment_q[0].end_time, rsp.end_time);
               compare_field("turnaround", segment_q[0].turnaround, rsp.turnaround);
               compare_field("waiting", segment_q[0].waiting, rsp.waiting);
               compare_field("last_segment", segment_q[0].last_segment, rsp.last_segment);
               if (segment_q[0].segment_kind == SEG_RUN) run_segments++;
               else idle_segments++;
               segment_q.pop_front();
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic push_entry(req_type p, int unsigned idle, int unsigned stall, bit drain);
      load_entry_type e;
      e.item = p;
      e.idle_pct = idle;
      e.stall_pct = stall;
      e.wait_drain = drain;
      load_q.push_back(e);
   endtask

   task automatic add_directed(logic [15:0] id, logic [15:0] arrival, logic [15:0] burst,
                               logic [15:0] prio, bit is_last);
      req_type p;
      p.process_id = id;
      p.arrival_time = arrival;
      p.burst_time = burst;
      p.priority_level = prio;
      p.last_process = is_last;
      push_entry(p, 0, 0, 1'b0);
   endtask

   // mostly short times so processes overlap; now and then anything, negatives included
   function automatic logic [15:0] rand_tick(int unsigned short_max);
      logic [15:0] r;
      case ($urandom_range(9))
         0: r = 16'($urandom);
         1: r = 16'h8000 | 16'($urandom_range(32767));
         2: r = 16'($urandom_range(32767));
         default: r = 16'($urandom_range(short_max));
      endcase
      return r;
   endfunction

   function automatic req_type random_process(bit is_last);
      req_type p;
      case ($urandom_range(7))
         0: p.process_id = 16'($urandom);
         1: p.process_id = 16'd0;
         default: p.process_id = 16'($urandom_range(1, 6));   // narrow ids force id ties
      endcase
      p.arrival_time = rand_tick(60);
      p.burst_time = rand_tick(20);
      case ($urandom_range(7))
         0: p.priority_level = 16'($urandom);
         1: p.priority_level = 16'hFFFF;
         2: p.priority_level = 16'd0;
         default: p.priority_level = 16'($urandom_range(3));  // narrow range forces ties
      endcase
      p.last_process = is_last;
      return p;
   endfunction

   initial begin : stimulus
      int unsigned queued, set_size, phase, last_phase, sets, pick, idle, stall;
      bit          drain;

      // single process, top priority
      add_directed(16'd1, 16'd0, 16'd5, 16'd0, 1'b1);
      // id zero with zero burst, arriving late: idle gap then an instant run
      add_directed(16'd0, 16'd100, 16'd0, 16'hFFFF, 1'b1);
      // negative arrival and burst clamp to zero; largest arrival and burst
      add_directed(16'hFFFF, 16'h8000, 16'hFFFF, 16'd7, 1'b0);
      add_directed(16'd2, 16'h7FFF, 16'h7FFF, 16'd0, 1'b0);
      add_directed(16'd9, 16'hFFFF, 16'h7FFF, 16'hFFFF, 1'b1);
      // priority ties: smaller id wins, equal ids fall back to the lower slot
      add_directed(16'd5, 16'd3, 16'd2, 16'd3, 1'b0);
      add_directed(16'd3, 16'd3, 16'd2, 16'd3, 1'b0);
      add_directed(16'd3, 16'd3, 16'd1, 16'd3, 1'b0);
      add_directed(16'd4, 16'd0, 16'd1, 16'd0, 1'b1);
      // gaps between runs: idle, run, idle, run
      add_directed(16'd7, 16'd50, 16'd10, 16'd1, 1'b0);
      add_directed(16'd8, 16'd200, 16'd5, 16'd0, 1'b1);

      // random sets in four pacing phases; mostly small sets, a few full or overfull
      queued = 0;
      sets = 0;
      last_phase = 0;
      while (queued < RANDOM_ITEMS) begin
         phase = queued * 4 / RANDOM_ITEMS;
         case (phase)
            0: begin
               idle = 0;
               stall = 0;
            end
            1: begin
               idle = 71;
               stall = 0;
            end
            2: begin
               idle = 0;
               stall = 71;
            end
            default: begin
               idle = 31;
               stall = 31;
            end
         endcase
         pick = $urandom_range(19);
         if (sets == 3) set_size = MAX_PROC + 2;           // overfull store on purpose
         else if (pick < 12) set_size = $urandom_range(1, 4);
         else if (pick < 17) set_size = $urandom_range(5, 12);
         else if (pick < 19) set_size = $urandom_range(13, MAX_PROC);
         else set_size = $urandom_range(MAX_PROC + 1, MAX_PROC + 4);
         // drain fully at each phase change and now and then in between
         drain = (phase != last_phase) || (sets == 1) || ($urandom_range(7) == 0);
         for (int k = 0; k < set_size; k++)
            push_entry(random_process(k == set_size - 1), idle, stall, drain && k == 0);
         queued += set_size;
         sets++;
         last_phase = phase;
      end

      while (load_q.size() != 0 || req_valid || segment_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("summary: %0d process transfers, %0d schedules, %0d dropped on a full store",
               items_loaded, schedule_count, dropped_count);
      $display("summary: %0d run and %0d idle segments checked", run_segments, idle_segments);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run under heavy stalling
   initial begin
      #5_000_000;
      $display("watchdog expired with %0d segments outstanding", segment_q.size());
      $display("tb: errors");
      $finish;
   end

endmodule
